// File: sv/sidfl_pkg.sv
// ============================================================================
// sidfl_pkg
// Shared types, widths and codes for the slot-ID free-list allocator.
// ============================================================================
package sidfl_pkg;

    localparam int SLOTS  = 1024;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = SLOT_W + 1;

    typedef logic [1:0]        t_func;
    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [2:0]        t_status;

    localparam t_func FUNC_ALLOC_NEXT = 2'd0;
    localparam t_func FUNC_ALLOC_AT   = 2'd1;
    localparam t_func FUNC_RELEASE    = 2'd2;

    localparam t_status ST_OK           = 3'd0;
    localparam t_status ST_ASSIGNED     = 3'd1;
    localparam t_status ST_FULL         = 3'd2;
    localparam t_status ST_RANGE        = 3'd3;
    localparam t_status ST_OCCUPIED     = 3'd4;
    localparam t_status ST_NOT_OCCUPIED = 3'd5;

    // end-of-list marker, also the limit reset value
    localparam t_cnt END_MARK    = t_cnt'(SLOTS);
    localparam t_cnt LIMIT_RESET = t_cnt'(SLOTS);

endpackage

// File: sv/sidfl_req_if.sv
// ============================================================================
// sidfl_req_if
// Request channel of the slot allocator: valid/ready plus request fields.
// ============================================================================
interface sidfl_req_if;
    logic               valid;
    logic               ready;
    sidfl_pkg::t_func   func;
    sidfl_pkg::t_slot   slot;
    logic               already_assigned;

    modport source (output valid, output func, output slot, output already_assigned,
                    input ready);
    modport sink   (input valid, input func, input slot, input already_assigned,
                    output ready);
endinterface

// File: sv/sidfl_rsp_if.sv
// ============================================================================
// sidfl_rsp_if
// Response channel of the slot allocator: valid/ready plus result fields.
// ============================================================================
interface sidfl_rsp_if;
    logic               valid;
    logic               ready;
    sidfl_pkg::t_status status;
    sidfl_pkg::t_slot   granted_slot;
    sidfl_pkg::t_cnt    live_count;

    modport source (output valid, output status, output granted_slot, output live_count,
                    input ready);
    modport sink   (input valid, input status, input granted_slot, input live_count,
                    output ready);
endinterface

// File: sv/sidfl_cfg_if.sv
// ============================================================================
// sidfl_cfg_if
// Configuration write channel: carries the slot limit register value.
// ============================================================================
interface sidfl_cfg_if;
    logic              valid;
    logic              ready;
    sidfl_pkg::t_cnt   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/slot_id_free_list_allocator.sv
// ============================================================================
// slot_id_free_list_allocator
// Hands out and takes back slot indices using a LIFO free list threaded
// through a per-slot link memory, a high-water extent and a live count.
// ============================================================================
// Usage:
//   i_req  : request channel (func, slot, already_assigned). Accepted when
//            valid and ready are high; ready is high only while the sequencer
//            is idle, so one request is in flight at a time.
//   o_rsp  : one response per request (status, granted_slot, live_count),
//            held in an output register until taken.
//   i_cfg  : writes slot_limit; always ready. Write only while idle.
// Steps from accept to response valid:
//   rejects at dispatch, allocate-next from the extent: answered at dispatch
//   allocate-next from the list, release, occupied target: one memory read
//   allocate-at the list head: unlink the head, then claim; deeper in the
//   list: walk the links, splice, claim; beyond the extent: fill, then claim
// Request ready rises together with response valid.
// List and occupancy traffic uses one port per memory with registered read
// data, one access per cycle during the list walk and the skipped-slot fill.
// Reset: head = end marker, extent and live count zero, limit 1024. The
// occupancy memory is not cleared: entries at or above the extent are treated
// as free and are written as the extent grows.
// If o_rsp stalls, the finished response waits in the output register and
// the next request is still taken; its result waits in the sequencer.
// ============================================================================
module slot_id_free_list_allocator (
    input  logic i_clk,
    input  logic i_rst_n,
    sidfl_req_if.sink   i_req,
    sidfl_rsp_if.source o_rsp,
    sidfl_cfg_if.sink   i_cfg
);
    import sidfl_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_POP      = 4'd2;
    localparam logic [3:0] S_AT_CHK   = 4'd3;
    localparam logic [3:0] S_UNHEAD   = 4'd4;
    localparam logic [3:0] S_WALK     = 4'd5;
    localparam logic [3:0] S_SPLICE   = 4'd6;
    localparam logic [3:0] S_CLAIM    = 4'd7;
    localparam logic [3:0] S_FILL     = 4'd8;
    localparam logic [3:0] S_REL_CHK  = 4'd9;
    localparam logic [3:0] S_RESP     = 4'd10;

    logic [3:0] r_state, n_state;
    t_func      r_func, n_func;
    t_slot      r_slot, n_slot;
    logic       r_assigned, n_assigned;
    t_cnt       r_head, n_head;
    t_cnt       r_extent, n_extent;
    t_cnt       r_live, n_live;
    t_cnt       r_limit;
    t_cnt       r_cur, n_cur;
    t_cnt       r_steps, n_steps;
    t_status    r_status, n_status;
    t_slot      r_granted, n_granted;
    logic       r_out_valid, n_out_valid;
    t_status    r_out_status;
    t_slot      r_out_granted;
    t_cnt       r_out_live;

    logic       r_occ_mem [SLOTS];
    t_cnt       r_link_mem [SLOTS];
    logic       r_occ_rd;
    t_cnt       r_link_rd;

    logic       occ_re, occ_we, occ_wdata;
    t_slot      occ_waddr;
    logic       link_re, link_we;
    t_slot      link_raddr, link_waddr;
    t_cnt       link_wdata;
    logic       out_load;

    t_cnt       eff_limit;
    t_cnt       slot_ext;
    t_cnt       steps_inc;

    assign eff_limit = (r_limit > END_MARK) ? END_MARK : r_limit;
    assign slot_ext  = {1'b0, r_slot};
    assign steps_inc = r_steps + t_cnt'(1);

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.granted_slot = r_out_granted;
    assign o_rsp.live_count   = r_out_live;

    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_slot      = r_slot;
        n_assigned  = r_assigned;
        n_head      = r_head;
        n_extent    = r_extent;
        n_live      = r_live;
        n_cur       = r_cur;
        n_steps     = r_steps;
        n_status    = r_status;
        n_granted   = r_granted;
        n_out_valid = r_out_valid & ~o_rsp.ready;
        out_load    = 1'b0;
        occ_re      = 1'b0;
        occ_we      = 1'b0;
        occ_waddr   = r_slot;
        occ_wdata   = 1'b0;
        link_re     = 1'b0;
        link_raddr  = r_slot;
        link_we     = 1'b0;
        link_waddr  = r_slot;
        link_wdata  = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_func     = i_req.func;
                    n_slot     = i_req.slot;
                    n_assigned = i_req.already_assigned;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_granted = '0;
                n_status  = ST_OK;
                n_state   = S_RESP;
                if (r_func != FUNC_ALLOC_NEXT && r_func != FUNC_ALLOC_AT
                        && r_func != FUNC_RELEASE) begin
                    n_status = ST_RANGE;
                end else if (r_func != FUNC_RELEASE && r_assigned) begin
                    n_status = ST_ASSIGNED;
                end else if (r_func == FUNC_ALLOC_NEXT) begin
                    if (r_head < END_MARK) begin
                        link_re    = 1'b1;
                        link_raddr = r_head[SLOT_W-1:0];
                        n_state    = S_POP;
                    end else if (r_extent < eff_limit) begin
                        occ_we    = 1'b1;
                        occ_waddr = r_extent[SLOT_W-1:0];
                        occ_wdata = 1'b1;
                        n_granted = r_extent[SLOT_W-1:0];
                        n_extent  = r_extent + t_cnt'(1);
                        n_live    = r_live + t_cnt'(1);
                    end else begin
                        n_status = ST_FULL;
                    end
                end else if (r_func == FUNC_ALLOC_AT) begin
                    if (slot_ext >= eff_limit) begin
                        n_status = ST_RANGE;
                    end else if (slot_ext < r_extent) begin
                        occ_re  = 1'b1;
                        n_state = S_AT_CHK;
                    end else begin
                        n_state = S_FILL;
                    end
                end else begin
                    // slots at or above the extent were never handed out
                    if (slot_ext >= r_extent) begin
                        n_status = ST_NOT_OCCUPIED;
                    end else begin
                        occ_re  = 1'b1;
                        n_state = S_REL_CHK;
                    end
                end
            end
            S_POP: begin
                occ_we    = 1'b1;
                occ_waddr = r_head[SLOT_W-1:0];
                occ_wdata = 1'b1;
                n_granted = r_head[SLOT_W-1:0];
                n_head    = r_link_rd;
                n_live    = r_live + t_cnt'(1);
                n_state   = S_RESP;
            end
            S_AT_CHK: begin
                if (r_occ_rd) begin
                    n_status = ST_OCCUPIED;
                    n_state  = S_RESP;
                end else if (r_head == slot_ext) begin
                    link_re = 1'b1;
                    n_state = S_UNHEAD;
                end else if (r_head < END_MARK) begin
                    link_re    = 1'b1;
                    link_raddr = r_head[SLOT_W-1:0];
                    n_cur      = r_head;
                    n_steps    = '0;
                    n_state    = S_WALK;
                end else begin
                    n_state = S_CLAIM;
                end
            end
            S_UNHEAD: begin
                n_head  = r_link_rd;
                n_state = S_CLAIM;
            end
            S_WALK: begin
                // r_link_rd is the successor of r_cur
                if (r_link_rd == slot_ext) begin
                    link_re = 1'b1;
                    n_state = S_SPLICE;
                end else begin
                    n_cur   = r_link_rd;
                    n_steps = steps_inc;
                    if (r_link_rd < END_MARK && steps_inc < END_MARK) begin
                        link_re    = 1'b1;
                        link_raddr = r_link_rd[SLOT_W-1:0];
                    end else begin
                        n_state = S_CLAIM;
                    end
                end
            end
            S_SPLICE: begin
                link_we    = 1'b1;
                link_waddr = r_cur[SLOT_W-1:0];
                link_wdata = r_link_rd;
                n_state    = S_CLAIM;
            end
            S_CLAIM: begin
                occ_we    = 1'b1;
                occ_wdata = 1'b1;
                n_granted = r_slot;
                n_live    = r_live + t_cnt'(1);
                n_state   = S_RESP;
            end
            S_FILL: begin
                if (r_extent < slot_ext) begin
                    // push the skipped slot and mark it free
                    link_we    = 1'b1;
                    link_waddr = r_extent[SLOT_W-1:0];
                    link_wdata = r_head;
                    occ_we     = 1'b1;
                    occ_waddr  = r_extent[SLOT_W-1:0];
                    n_head     = r_extent;
                    n_extent   = r_extent + t_cnt'(1);
                end else begin
                    occ_we    = 1'b1;
                    occ_wdata = 1'b1;
                    n_extent  = slot_ext + t_cnt'(1);
                    n_granted = r_slot;
                    n_live    = r_live + t_cnt'(1);
                    n_state   = S_RESP;
                end
            end
            S_REL_CHK: begin
                if (!r_occ_rd) begin
                    n_status = ST_NOT_OCCUPIED;
                end else begin
                    occ_we     = 1'b1;
                    link_we    = 1'b1;
                    link_wdata = r_head;
                    n_head     = slot_ext;
                    n_granted  = r_slot;
                    if (r_live != '0) begin
                        n_live = r_live - t_cnt'(1);
                    end
                end
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!r_out_valid || o_rsp.ready) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= END_MARK;
            r_extent    <= '0;
            r_live      <= '0;
            r_limit     <= LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_extent    <= n_extent;
            r_live      <= n_live;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                r_limit <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_slot     <= n_slot;
        r_assigned <= n_assigned;
        r_cur      <= n_cur;
        r_steps    <= n_steps;
        r_status   <= n_status;
        r_granted  <= n_granted;
        if (out_load) begin
            r_out_status  <= r_status;
            r_out_granted <= (r_status == ST_OK) ? r_granted : '0;
            r_out_live    <= r_live;
        end
    end

    // occupancy memory
    always_ff @(posedge i_clk) begin
        if (occ_we) begin
            r_occ_mem[occ_waddr] <= occ_wdata;
        end
        if (occ_re) begin
            r_occ_rd <= r_occ_mem[r_slot];
        end
    end

    // free-list link memory
    always_ff @(posedge i_clk) begin
        if (link_we) begin
            r_link_mem[link_waddr] <= link_wdata;
        end
        if (link_re) begin
            r_link_rd <= r_link_mem[link_raddr];
        end
    end

endmodule

// File: sv/sidfl_checker.sv
// ============================================================================
// sidfl_checker
// Port-level checks for the slot allocator, bound to the top level.
// ============================================================================
module sidfl_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_req_valid,
    input logic                i_req_ready,
    input logic                i_rsp_valid,
    input logic                i_rsp_ready,
    input sidfl_pkg::t_status  i_rsp_status,
    input sidfl_pkg::t_slot    i_rsp_granted_slot,
    input sidfl_pkg::t_cnt     i_rsp_live_count
);
    import sidfl_pkg::*;

    // a pending response holds until taken
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_status)
            && $stable(i_rsp_granted_slot) && $stable(i_rsp_live_count))
        else $error("response dropped or changed while stalled");

    // one request in flight: busy right after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while previous one in flight");

    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status != ST_OK |-> i_rsp_granted_slot == '0)
        else $error("granted slot nonzero on failed request");

    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_rsp_live_count <= END_MARK && i_rsp_status <= ST_NOT_OCCUPIED)
        else $error("live count or status out of range");

endmodule

bind slot_id_free_list_allocator sidfl_checker u_sidfl_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_req_valid        (i_req.valid),
    .i_req_ready        (i_req.ready),
    .i_rsp_valid        (o_rsp.valid),
    .i_rsp_ready        (o_rsp.ready),
    .i_rsp_status       (o_rsp.status),
    .i_rsp_granted_slot (o_rsp.granted_slot),
    .i_rsp_live_count   (o_rsp.live_count)
);
